// ----- rtl/gblit_pkg.sv -----
// Shared types and constants for the 8x8 glyph blitter.
package gblit_pkg;

  localparam int GlyphSize  = 8;
  localparam int FontStride = 128;
  localparam int FontDepth  = 16384;
  localparam int FontWords  = FontDepth / GlyphSize;
  localparam int WordAddrW  = $clog2(FontWords);
  localparam int LaneW      = $clog2(GlyphSize);
  localparam int RowStepW   = $clog2(FontStride / GlyphSize);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_ROW_STRIDE    = 2'd2,
    CFG_BUFFER_BASE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                operation;
    logic [13:0]        font_addr;
    logic [7:0]         font_byte;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         char_code;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dest_addr;
    logic [63:0] row_pixels;
    logic [7:0]  write_mask;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [13:0] row_stride;
    logic [31:0] buffer_base;
  } cfg_t;

  typedef struct packed {
    logic                 en;
    logic [WordAddrW-1:0] addr;
    logic [LaneW-1:0]     lane;
    logic [7:0]           data;
  } mem_wr_t;

  typedef struct packed {
    logic                 en;
    logic [WordAddrW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] dest_addr;
    logic        last_row;
  } row_tag_t;

endpackage

// ----- rtl/gblit_font_mem.sv -----
// Font store: one 64-bit glyph row per word, byte-lane writes, registered read.
module gblit_font_mem
  import gblit_pkg::*;
(
  input  logic        clk,
  input  mem_wr_t     wr,
  input  mem_rd_t     rd,
  output logic [63:0] rd_data
);

  logic [63:0] mem [FontWords];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][wr.lane*8 +: 8] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ----- rtl/gblit_seq.sv -----
// Item sequencer: font loads, draw clipping, row address generation and read issue.
module gblit_seq
  import gblit_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  in_item_t item,
  input  cfg_t     cfg,
  input  logic     issue_ok,
  output mem_wr_t  mem_wr,
  output mem_rd_t  mem_rd,
  output row_tag_t tag
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_ADDR,
    S_RUN
  } state_t;

  state_t             state;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [7:0]         code;
  logic [28:0]        prod;
  logic [31:0]        addr;
  logic [2:0]         grow;
  logic [3:0]         rows_left;

  logic signed [17:0] px_w, py_w, w_lim, h_lim;
  logic               drop;
  logic [14:0]        frame_row;
  logic [2:0]         grow_start;
  logic               xfer;

  assign item_ready = (state == S_IDLE);
  assign xfer       = item_valid && item_ready;

  always_comb begin
    px_w       = $signed({{2{px[15]}}, px});
    py_w       = $signed({{2{py[15]}}, py});
    w_lim      = $signed({5'd0, cfg.screen_width}) - 18'sd8;
    h_lim      = $signed({5'd0, cfg.screen_height}) - 18'sd8;
    drop       = (py_w <= -18'sd8) || (py_w > h_lim) || px[15] || (px_w > w_lim);
    frame_row  = py[15] ? 15'd0 : py[14:0];
    grow_start = py[15] ? 3'(~py[2:0] + 3'd1) : 3'd0;
  end

  always_comb begin
    mem_wr.en   = xfer && (item.operation == OP_LOAD);
    mem_wr.addr = item.font_addr[13:LaneW];
    mem_wr.lane = item.font_addr[LaneW-1:0];
    mem_wr.data = item.font_byte;

    mem_rd.en   = (state == S_RUN) && issue_ok;
    mem_rd.addr = {code[7:4], grow, code[3:0]};

    tag.vld       = mem_rd.en;
    tag.dest_addr = addr;
    tag.last_row  = (rows_left == 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (xfer && item.operation == OP_DRAW) begin
            px    <= item.pos_x;
            py    <= item.pos_y;
            code  <= item.char_code;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          prod      <= 29'({14'd0, frame_row} * {15'd0, cfg.row_stride});
          grow      <= grow_start;
          rows_left <= 4'd8 - {1'b0, grow_start};
          state     <= drop ? S_IDLE : S_ADDR;
        end
        S_ADDR: begin
          addr  <= cfg.buffer_base + {3'd0, prod} + {16'd0, px};
          state <= S_RUN;
        end
        S_RUN: begin
          if (issue_ok) begin
            addr      <= addr + {18'd0, cfg.row_stride};
            grow      <= grow + 3'd1;
            rows_left <= rows_left - 4'd1;
            if (rows_left == 4'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  row_step_width_a: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (rows_left != 4'd0))
    else $error("row counter empty while issuing");

  no_write_during_draw_a: assert property (@(posedge clk) disable iff (rst)
    mem_rd.en |-> !mem_wr.en)
    else $error("font write overlaps row read");

  last_row_ends_run_a: assert property (@(posedge clk) disable iff (rst)
    (tag.vld && tag.last_row) |=> (state == S_IDLE))
    else $error("draw continued past last row");

  localparam int RowStepCheck = RowStepW;

  glyph_row_field_a: assert property (@(posedge clk) disable iff (rst)
    mem_rd.en |-> (mem_rd.addr[RowStepCheck +: 3] == grow))
    else $error("glyph row misplaced in word address");

endmodule

// ----- rtl/gblit_out.sv -----
// Result stage: read data capture, write mask, skid and output registers, issue credit.
module gblit_out
  import gblit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  row_tag_t    tag,
  input  logic [63:0] rd_data,
  output logic        issue_ok,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result
);

  logic        tag_vld;
  logic [31:0] tag_addr;
  logic        tag_last;
  logic        skid_vld;
  out_item_t   skid;
  out_item_t   fresh;
  logic        out_free;
  logic        xfer;
  logic [1:0]  occ;

  always_comb begin
    fresh.dest_addr  = tag_addr;
    fresh.row_pixels = rd_data;
    fresh.last_row   = tag_last;
    for (int i = 0; i < GlyphSize; i++) begin
      fresh.write_mask[i] = (rd_data[i*8 +: 8] != 8'd0);
    end
  end

  assign xfer     = result_valid && result_ready;
  assign out_free = !result_valid || result_ready;
  assign occ      = 2'(tag_vld) + 2'(skid_vld) + 2'(result_valid) - 2'(xfer);
  assign issue_ok = (occ <= 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_vld      <= 1'b0;
      skid_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      tag_vld <= tag.vld;
      if (out_free) begin
        if (skid_vld) begin
          result       <= skid;
          result_valid <= 1'b1;
          skid         <= fresh;
          skid_vld     <= tag_vld;
        end else begin
          result       <= fresh;
          result_valid <= tag_vld;
        end
      end else if (tag_vld) begin
        skid     <= fresh;
        skid_vld <= 1'b1;
      end
    end
    if (tag.vld) begin
      tag_addr <= tag.dest_addr;
      tag_last <= tag.last_row;
    end
  end

  skid_no_overflow_a: assert property (@(posedge clk) disable iff (rst)
    (tag_vld && result_valid && !result_ready) |-> !skid_vld)
    else $error("skid register overrun");

  skid_behind_out_a: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> result_valid)
    else $error("skid holds a row while output is empty");

  mask_matches_pixels_a: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.write_mask[0] == (result.row_pixels[7:0] != 8'd0)) &&
                     (result.write_mask[7] == (result.row_pixels[63:56] != 8'd0)))
    else $error("write mask disagrees with pixels");

endmodule

// ----- rtl/glyph_blitter_8x8_core.sv -----
// Top level of the 8x8 glyph blitter: configuration registers and block wiring.
// A load transfer writes one font byte. A draw first does the clipping checks
// and the row-times-stride product, then the start address, and then one read
// per drawn row, 1 to 8 rows; a rejected draw returns to idle after the checks.
// Each row is one read of the font store's single read port, which sets the
// row rate; stalls on the result channel pause row reads once the two-entry
// result buffer is committed. The next item is taken as soon as the last row
// read of a draw has been issued, while earlier rows still drain.
module glyph_blitter_8x8_core
  import gblit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t        cfg;
  mem_wr_t     mem_wr;
  mem_rd_t     mem_rd;
  row_tag_t    tag;
  logic [63:0] rd_data;
  logic        issue_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd320;
      cfg.screen_height <= 13'd200;
      cfg.row_stride    <= 14'd320;
      cfg.buffer_base   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[12:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[12:0];
        CFG_ROW_STRIDE:    cfg.row_stride    <= cfg_data[13:0];
        CFG_BUFFER_BASE:   cfg.buffer_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  gblit_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg        (cfg),
    .issue_ok   (issue_ok),
    .mem_wr     (mem_wr),
    .mem_rd     (mem_rd),
    .tag        (tag)
  );

  gblit_font_mem u_font_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  gblit_out u_out (
    .clk          (clk),
    .rst          (rst),
    .tag          (tag),
    .rd_data      (rd_data),
    .issue_ok     (issue_ok),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
